>>> hw/rtl/uv_sphere_vertex_generator_macros.svh
// Assertion macros shared by the UV sphere vertex generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uvs assertion failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uvs assertion failed");

`endif

>>> hw/rtl/uvs_pkg.sv
// Package for the UV sphere vertex generator: types, constants, CORDIC table,
// divider and CORDIC step functions. No dependencies.
package uvs_pkg;

	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned CORDIC_TABLE_LEN  = 24;
	localparam int unsigned DIV_STEPS         = 33;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W            = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REG_RING_COUNT    = 2'd0;
	localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
	localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

	localparam logic [7:0]  RING_COUNT_RST    = 8'd16;
	localparam logic [7:0]  SEGMENT_COUNT_RST = 8'd16;
	localparam logic [15:0] SPHERE_RADIUS_RST = 16'd256;

	localparam logic [7:0] RINGS_MIN = 8'd2;
	localparam logic [7:0] SEGS_MIN  = 8'd3;
	localparam logic [7:0] COUNT_MAX = 8'd254;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

	localparam logic signed [31:0] ATAN_TURNS [CORDIC_TABLE_LEN] = '{
		32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
		32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2E,
		32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
		32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
		32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
	};

	typedef struct packed {
		logic [7:0]  ring;
		logic [7:0]  seg;
		logic [7:0]  rings;
		logic [7:0]  segs;
		logic [15:0] radius;
		logic [15:0] corner_upper;
		logic [15:0] corner_lower;
		logic        quad_valid;
	} item_t;

	typedef struct packed {
		logic [7:0]  rem;
		logic [32:0] quo;
		logic        rnd16;
		logic        rnd31;
		logic        rnd32;
	} div_t;

	typedef struct packed {
		item_t it;
		div_t  dr;
		div_t  ds;
	} div_stg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} rot_t;

	typedef struct packed {
		logic [15:0] corner_upper;
		logic [15:0] corner_lower;
		logic        quad_valid;
		logic [15:0] radius;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
	} side_t;

	typedef struct packed {
		rot_t       t;
		rot_t       p;
		logic [1:0] qt;
		logic [1:0] qp;
		side_t      side;
	} cor_t;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] c;
	} sc_t;

	// one restoring step of num * 2^j / d; rounding bits latched at j = 16, 31, 32
	function automatic div_t div_step(div_t p, logic [7:0] num, logic [7:0] d, logic [5:0] j);
		logic [8:0] r2;
		logic [8:0] rs;
		logic       ge;
		logic [7:0] half_up;
		div_t       n;
		half_up = 8'(({1'b0, d} + 9'd1) >> 1);
		r2 = (j == 6'd0) ? {1'b0, num} : {p.rem, 1'b0};
		ge = r2 >= {1'b0, d};
		rs = ge ? (r2 - {1'b0, d}) : r2;
		n = p;
		n.rem = rs[7:0];
		n.quo = (j == 6'd0) ? {32'd0, ge} : {p.quo[31:0], ge};
		if (j == 6'd16) begin
			n.rnd16 = rs[7:0] >= half_up;
		end
		if (j == 6'd31) begin
			n.rnd31 = rs[7:0] >= half_up;
		end
		if (j == 6'd32) begin
			n.rnd32 = rs[7:0] >= half_up;
		end
		return n;
	endfunction

	function automatic rot_t rot_step(rot_t a, logic [4:0] i);
		rot_t n;
		if (!a.z[31]) begin
			n.x = a.x - (a.y >>> i);
			n.y = a.y + (a.x >>> i);
			n.z = a.z - ATAN_TURNS[i];
		end else begin
			n.x = a.x + (a.y >>> i);
			n.y = a.y - (a.x >>> i);
			n.z = a.z + ATAN_TURNS[i];
		end
		return n;
	endfunction

	function automatic logic signed [31:0] clamp_q30(logic signed [31:0] v);
		logic signed [31:0] r;
		if (v > ONE_Q30) begin
			r = ONE_Q30;
		end else if (v < -ONE_Q30) begin
			r = -ONE_Q30;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic sc_t quad_map(rot_t r, logic [1:0] q);
		sc_t o;
		case (q)
			2'd0: begin
				o.s = r.y;
				o.c = r.x;
			end
			2'd1: begin
				o.s = r.x;
				o.c = -r.y;
			end
			2'd2: begin
				o.s = -r.y;
				o.c = -r.x;
			end
			default: begin
				o.s = -r.x;
				o.c = r.y;
			end
		endcase
		o.s = clamp_q30(o.s);
		o.c = clamp_q30(o.c);
		return o;
	endfunction

endpackage

>>> hw/rtl/uv_sphere_vertex_generator.sv
// Pipeline from a taken start to the done pulse:
// 33 divider stages fed from the queue head, one angle stage, the CORDIC stages, five output stages.
// Throughput: one vertex per cycle while busy is low; busy rises only if the two-entry queue fills.
// Reset: arst_n clears all valid bits and restores ring_count 16, segment_count 16, radius 256.
// The receiver cannot stall: each result is on the ports for the single cycle done is high.
`include "uv_sphere_vertex_generator_macros.svh"
module uv_sphere_vertex_generator #(
	parameter int unsigned CORDIC_STAGES = uvs_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         ring_index,
	input  logic [7:0]         segment_index,
	output logic               done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        corner_upper,
	output logic [15:0]        corner_lower,
	output logic               quad_valid
);
	import uvs_pkg::*;

	logic  push, q_full, pop_valid;
	item_t push_item, pop_item;

	assign busy = q_full;

	uvs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.ring_index    (ring_index),
		.segment_index (segment_index),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	uvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	uvs_back #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pop_valid),
		.in_item      (pop_item),
		.done         (done),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.corner_upper (corner_upper),
		.corner_lower (corner_lower),
		.quad_valid   (quad_valid)
	);

	`UVS_ASSERT_IMPL(a_tex_range, clk, arst_n, done, (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
	`UVS_ASSERT_IMPL(a_quad_tex, clk, arst_n, done && quad_valid, (tex_u != 17'd0) && (tex_v != 17'd65536))
	`UVS_ASSERT_IMPL(a_norm_y, clk, arst_n, done, (norm_y >= -16'sd16384) && (norm_y <= 16'sd16384))

endmodule

>>> hw/rtl/uvs_front.sv
// Front end: configuration registers, count/index clamping, corner indices.
// Depends on uvs_pkg.
module uvs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               start,
	input  logic [7:0]         ring_index,
	input  logic [7:0]         segment_index,
	input  logic               q_full,
	output logic               push,
	output uvs_pkg::item_t     push_item
);
	import uvs_pkg::*;

	logic [7:0]  ring_count_q;
	logic [7:0]  segment_count_q;
	logic [15:0] sphere_radius_q;
	logic [7:0]  rings, segs, ring, seg;
	logic [16:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= RING_COUNT_RST;
			segment_count_q <= SEGMENT_COUNT_RST;
			sphere_radius_q <= SPHERE_RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_COUNT:    ring_count_q    <= cfg_data[7:0];
				REG_SEGMENT_COUNT: segment_count_q <= cfg_data[7:0];
				REG_SPHERE_RADIUS: sphere_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rings = (ring_count_q < RINGS_MIN) ? RINGS_MIN :
			(ring_count_q > COUNT_MAX) ? COUNT_MAX : ring_count_q;
		segs = (segment_count_q < SEGS_MIN) ? SEGS_MIN :
			(segment_count_q > COUNT_MAX) ? COUNT_MAX : segment_count_q;
		ring = (ring_index > rings) ? rings : ring_index;
		seg  = (segment_index > segs) ? segs : segment_index;
		prod = 17'(ring) * (17'(segs) + 17'd1) + 17'(seg);
		push_item.ring         = ring;
		push_item.seg          = seg;
		push_item.rings        = rings;
		push_item.segs         = segs;
		push_item.radius       = sphere_radius_q;
		push_item.corner_upper = prod[15:0];
		push_item.corner_lower = prod[15:0] + 16'(segs) + 16'd1;
		push_item.quad_valid   = (ring < rings) && (seg < segs);
		push = start && !q_full;
	end

endmodule

>>> hw/rtl/uvs_queue.sv
// Two-entry transaction queue between front end and back end.
// Depends on uvs_pkg and the assertion macro header.
`include "uv_sphere_vertex_generator_macros.svh"
module uvs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uvs_pkg::item_t push_item,
	output logic           full,
	output logic           pop_valid,
	output uvs_pkg::item_t pop_item
);
	import uvs_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_valid) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop_valid})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`UVS_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))
	`UVS_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !full)
	`UVS_ASSERT_NEXT(a_drain, clk, arst_n, !push && pop_valid, cnt_q == $past(cnt_q) - QCNT_W'(1))

endmodule

>>> hw/rtl/uvs_back.sv
// Back end: pipelined angle divider, two CORDIC pipelines, products, rounding.
// Depends on uvs_pkg.
module uvs_back #(
	parameter int unsigned CORDIC_STAGES = uvs_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  uvs_pkg::item_t     in_item,
	output logic               done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        corner_upper,
	output logic [15:0]        corner_lower,
	output logic               quad_valid
);
	import uvs_pkg::*;

	typedef struct packed {
		sc_t   t;
		sc_t   p;
		side_t side;
	} trig_t;

	typedef struct packed {
		logic signed [63:0] px;
		logic signed [63:0] pz;
		logic signed [31:0] ct;
		side_t              side;
	} prod_t;

	typedef struct packed {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		side_t              side;
	} q_t;

	typedef struct packed {
		logic signed [48:0] ppx;
		logic signed [48:0] ppy;
		logic signed [48:0] ppz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		side_t              side;
	} pm_t;

	div_stg_t                 div_s [DIV_STEPS];
	logic [DIV_STEPS-1:0]     div_v_s;
	cor_t                     cor_in_s1;
	logic                     cor_in_v_s1;
	cor_t                     cor_s [CORDIC_STAGES];
	logic [CORDIC_STAGES-1:0] cor_v_s;
	trig_t                    trig_s2;
	prod_t                    prod_s3;
	q_t                       q_s4;
	pm_t                      pm_s5;
	logic                     v_s2, v_s3, v_s4, v_s5;

	logic [31:0]        theta;
	logic [32:0]        phi_w;
	logic [16:0]        tv, tu_sub;
	logic signed [31:0] tnx, tny, tnz;
	logic signed [48:0] rpx, rpy, rpz;
	logic signed [48:0] fpx, fpy, fpz;

	// divider pipeline, one quotient bit per stage for both counts
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				div_s[0].it <= in_item;
				div_s[0].dr <= div_step('0, in_item.ring, in_item.rings, 6'd0);
				div_s[0].ds <= div_step('0, in_item.seg, in_item.segs, 6'd0);
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				div_s[j].it <= div_s[j-1].it;
				div_s[j].dr <= div_step(div_s[j-1].dr, div_s[j-1].it.ring,
					div_s[j-1].it.rings, 6'(j));
				div_s[j].ds <= div_step(div_s[j-1].ds, div_s[j-1].it.seg,
					div_s[j-1].it.segs, 6'(j));
			end
		end
	end

	always_comb begin
		theta  = div_s[DIV_STEPS-1].dr.quo[32:1] + 32'(div_s[DIV_STEPS-1].dr.rnd31);
		phi_w  = div_s[DIV_STEPS-1].ds.quo + 33'(div_s[DIV_STEPS-1].ds.rnd32);
		tv     = div_s[DIV_STEPS-1].dr.quo[32:16] + 17'(div_s[DIV_STEPS-1].dr.rnd16);
		tu_sub = div_s[DIV_STEPS-1].ds.quo[32:16] + 17'(div_s[DIV_STEPS-1].ds.rnd16);
	end

	always_ff @(posedge clk) begin
		cor_in_s1.t.x <= CORDIC_GAIN;
		cor_in_s1.t.y <= '0;
		cor_in_s1.t.z <= $signed({2'b00, theta[29:0]});
		cor_in_s1.qt  <= theta[31:30];
		cor_in_s1.p.x <= CORDIC_GAIN;
		cor_in_s1.p.y <= '0;
		cor_in_s1.p.z <= $signed({2'b00, phi_w[29:0]});
		cor_in_s1.qp  <= phi_w[31:30];
		cor_in_s1.side.corner_upper <= div_s[DIV_STEPS-1].it.corner_upper;
		cor_in_s1.side.corner_lower <= div_s[DIV_STEPS-1].it.corner_lower;
		cor_in_s1.side.quad_valid   <= div_s[DIV_STEPS-1].it.quad_valid;
		cor_in_s1.side.radius       <= div_s[DIV_STEPS-1].it.radius;
		cor_in_s1.side.tex_v        <= tv;
		cor_in_s1.side.tex_u        <= 17'd65536 - tu_sub;
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				cor_s[0].t    <= rot_step(cor_in_s1.t, 5'd0);
				cor_s[0].p    <= rot_step(cor_in_s1.p, 5'd0);
				cor_s[0].qt   <= cor_in_s1.qt;
				cor_s[0].qp   <= cor_in_s1.qp;
				cor_s[0].side <= cor_in_s1.side;
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				cor_s[i].t    <= rot_step(cor_s[i-1].t, 5'(i));
				cor_s[i].p    <= rot_step(cor_s[i-1].p, 5'(i));
				cor_s[i].qt   <= cor_s[i-1].qt;
				cor_s[i].qp   <= cor_s[i-1].qp;
				cor_s[i].side <= cor_s[i-1].side;
			end
		end
	end

	always_comb begin
		tnx = q_s4.qx + 32'sd32768;
		tny = q_s4.qy + 32'sd32768;
		tnz = q_s4.qz + 32'sd32768;
		rpx = $signed({1'b0, q_s4.side.radius}) * q_s4.qx;
		rpy = $signed({1'b0, q_s4.side.radius}) * q_s4.qy;
		rpz = $signed({1'b0, q_s4.side.radius}) * q_s4.qz;
		fpx = (pm_s5.ppx + 49'sd536870912) >>> 30;
		fpy = (pm_s5.ppy + 49'sd536870912) >>> 30;
		fpz = (pm_s5.ppz + 49'sd536870912) >>> 30;
	end

	function automatic logic signed [15:0] to_norm(logic signed [31:0] t);
		logic signed [31:0] v;
		v = t >>> 16;
		if (v > 32'sd16384) begin
			v = 32'sd16384;
		end else if (v < -32'sd16384) begin
			v = -32'sd16384;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [16:0] to_pos(logic signed [48:0] v);
		logic signed [48:0] c;
		if (v > 49'sd65535) begin
			c = 49'sd65535;
		end else if (v < -49'sd65535) begin
			c = -49'sd65535;
		end else begin
			c = v;
		end
		return c[16:0];
	endfunction

	logic signed [63:0] sx, sz;
	assign sx = prod_s3.px + 64'sd536870912;
	assign sz = prod_s3.pz + 64'sd536870912;

	always_ff @(posedge clk) begin
		trig_s2.t    <= quad_map(cor_s[CORDIC_STAGES-1].t, cor_s[CORDIC_STAGES-1].qt);
		trig_s2.p    <= quad_map(cor_s[CORDIC_STAGES-1].p, cor_s[CORDIC_STAGES-1].qp);
		trig_s2.side <= cor_s[CORDIC_STAGES-1].side;

		prod_s3.px   <= trig_s2.t.s * trig_s2.p.s;
		prod_s3.pz   <= trig_s2.t.s * trig_s2.p.c;
		prod_s3.ct   <= trig_s2.t.c;
		prod_s3.side <= trig_s2.side;

		q_s4.qx   <= $signed(sx[61:30]);
		q_s4.qz   <= $signed(sz[61:30]);
		q_s4.qy   <= prod_s3.ct;
		q_s4.side <= prod_s3.side;

		pm_s5.ppx  <= rpx;
		pm_s5.ppy  <= rpy;
		pm_s5.ppz  <= rpz;
		pm_s5.nx   <= to_norm(tnx);
		pm_s5.ny   <= to_norm(tny);
		pm_s5.nz   <= to_norm(tnz);
		pm_s5.side <= q_s4.side;

		pos_x        <= to_pos(fpx);
		pos_y        <= to_pos(fpy);
		pos_z        <= to_pos(fpz);
		norm_x       <= pm_s5.nx;
		norm_y       <= pm_s5.ny;
		norm_z       <= pm_s5.nz;
		tex_u        <= pm_s5.side.tex_u;
		tex_v        <= pm_s5.side.tex_v;
		corner_upper <= pm_s5.side.corner_upper;
		corner_lower <= pm_s5.side.corner_lower;
		quad_valid   <= pm_s5.side.quad_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s     <= '0;
			cor_in_v_s1 <= 1'b0;
			cor_v_s     <= '0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			done        <= 1'b0;
		end else begin
			div_v_s     <= {div_v_s[DIV_STEPS-2:0], in_valid};
			cor_in_v_s1 <= div_v_s[DIV_STEPS-1];
			if (CORDIC_STAGES > 1) begin
				cor_v_s <= {cor_v_s[CORDIC_STAGES-2:0], cor_in_v_s1};
			end else begin
				cor_v_s <= cor_in_v_s1;
			end
			v_s2 <= cor_v_s[CORDIC_STAGES-1];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

endmodule

>>> sim/tb_uv_sphere_vertex_generator.sv
// Self-checking testbench for uv_sphere_vertex_generator: directed table, then random
// vertex requests under several ring, segment and radius settings. Needs uvs_pkg and the RTL.
`timescale 1ns / 100ps
module tb_uv_sphere_vertex_generator;
	import uvs_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		logic signed [16:0] pos_x, pos_y, pos_z;
		logic signed [15:0] norm_x, norm_y, norm_z;
		logic [16:0]        tex_u, tex_v;
		logic [15:0]        corner_upper, corner_lower;
		logic               quad_valid;
	} vertex_t;

	typedef struct {
		logic [7:0]  ring, seg;
		bit          typed;
		logic [16:0] u, v;
		logic [15:0] up, lo;
		logic        qv;
	} row_t;

	logic clk, arst_n, cfg_we, start, busy, done, quad_valid;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic [7:0]  ring_index, segment_index;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic [16:0] tex_u, tex_v;
	logic [15:0] corner_upper, corner_lower;

	logic [7:0]  m_rings, m_segs;
	logic [15:0] m_radius;
	vertex_t     vertex_q[$];
	int          errors = 0;
	int          cycles = 0;
	bit          no_gaps;

	uv_sphere_vertex_generator DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t timeout", $time);
			$display("tb_uv_sphere_vertex_generator failed");
			$finish;
		end
	end

	function automatic void sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
		longint x, y, z, nx;
		x = CORDIC_GAIN;
		y = 0;
		z = longint'(ang[29:0]);
		for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_TURNS[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_TURNS[i];
			end
			x = nx;
		end
		case (ang[31:30])
			2'd0: begin sn = y; cs = x; end
			2'd1: begin sn = x; cs = -y; end
			2'd2: begin sn = -y; cs = -x; end
			default: begin sn = -x; cs = y; end
		endcase
		if (sn > ONE_Q30) sn = ONE_Q30;
		if (sn < -ONE_Q30) sn = -ONE_Q30;
		if (cs > ONE_Q30) cs = ONE_Q30;
		if (cs < -ONE_Q30) cs = -ONE_Q30;
	endfunction

	function automatic longint lim(longint v, longint m);
		return v > m ? m : (v < -m ? -m : v);
	endfunction

	function automatic longint to_norm(longint q);
		return lim((q + 32768) >>> 16, 16384);
	endfunction

	function automatic longint to_pos(longint q);
		return lim((longint'(m_radius) * q + (64'sd1 << 29)) >>> 30, 65535);
	endfunction

	function automatic vertex_t vertex_model(logic [7:0] ring_in, logic [7:0] seg_in);
		longint rings, segs, ring, seg, st, ct, sp, cp, qx, qz, upper;
		logic [31:0] theta, phi;
		vertex_t v;
		rings = m_rings < 2 ? 2 : (m_rings > 254 ? 254 : m_rings);
		segs = m_segs < 3 ? 3 : (m_segs > 254 ? 254 : m_segs);
		ring = ring_in > rings ? rings : ring_in;
		seg = seg_in > segs ? segs : seg_in;
		theta = 32'(((ring << 31) + rings / 2) / rings);
		phi = 32'(((seg << 32) + segs / 2) / segs);
		sin_cos(theta, st, ct);
		sin_cos(phi, sp, cp);
		qx = (st * sp + (64'sd1 << 29)) >>> 30;
		qz = (st * cp + (64'sd1 << 29)) >>> 30;
		v.pos_x = 17'(to_pos(qx));
		v.pos_y = 17'(to_pos(ct));
		v.pos_z = 17'(to_pos(qz));
		v.norm_x = 16'(to_norm(qx));
		v.norm_y = 16'(to_norm(ct));
		v.norm_z = 16'(to_norm(qz));
		v.tex_u = 17'(65536 - ((seg << 16) + segs / 2) / segs);
		v.tex_v = 17'(((ring << 16) + rings / 2) / rings);
		upper = ring * (segs + 1) + seg;
		v.corner_upper = 16'(upper);
		v.corner_lower = 16'(upper + segs + 1);
		v.quad_valid = ring < rings && seg < segs;
		return v;
	endfunction

	function automatic void check_field(string name, longint e, longint a);
		if (e != a) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		vertex_t e;
		if (done) begin
			if (vertex_q.size() == 0) begin
				$display("%0t unexpected transaction: expected none actual corner_upper %0d",
					$time, corner_upper);
				errors++;
			end else begin
				e = vertex_q.pop_front();
				check_field("pos_x", e.pos_x, pos_x);
				check_field("pos_y", e.pos_y, pos_y);
				check_field("pos_z", e.pos_z, pos_z);
				check_field("norm_x", e.norm_x, norm_x);
				check_field("norm_y", e.norm_y, norm_y);
				check_field("norm_z", e.norm_z, norm_z);
				check_field("tex_u", e.tex_u, tex_u);
				check_field("tex_v", e.tex_v, tex_v);
				check_field("corner_upper", e.corner_upper, corner_upper);
				check_field("corner_lower", e.corner_lower, corner_lower);
				check_field("quad_valid", e.quad_valid, quad_valid);
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RING_COUNT: m_rings = data[7:0];
			REG_SEGMENT_COUNT: m_segs = data[7:0];
			REG_SPHERE_RADIUS: m_radius = data;
			default: ;
		endcase
	endtask

	task automatic send_vertex(row_t r);
		vertex_t v;
		start <= 1'b1;
		ring_index <= r.ring;
		segment_index <= r.seg;
		@(posedge clk);
		while (busy) @(posedge clk);
		v = vertex_model(r.ring, r.seg);
		if (r.typed) begin
			v.tex_u = r.u;
			v.tex_v = r.v;
			v.corner_upper = r.up;
			v.corner_lower = r.lo;
			v.quad_valid = r.qv;
		end
		vertex_q.push_back(v);
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	row_t directed[] = '{
		'{8'd0, 8'd0, 1, 17'd65536, 17'd0, 16'd0, 16'd17, 1'b1},
		'{8'd16, 8'd16, 1, 17'd0, 17'd65536, 16'd288, 16'd305, 1'b0},
		'{8'd255, 8'd255, 1, 17'd0, 17'd65536, 16'd288, 16'd305, 1'b0},
		'{8'd8, 8'd4, 1, 17'd49152, 17'd32768, 16'd140, 16'd157, 1'b1},
		'{8'd15, 8'd15, 1, 17'd4096, 17'd61440, 16'd270, 16'd287, 1'b1},
		'{8'd16, 8'd0, 1, 17'd65536, 17'd65536, 16'd272, 16'd289, 1'b0},
		'{8'd0, 8'd16, 1, 17'd0, 17'd0, 16'd16, 16'd33, 1'b0},
		'{8'd4, 8'd0, 0, 0, 0, 0, 0, 0},
		'{8'd4, 8'd8, 0, 0, 0, 0, 0, 0},
		'{8'd12, 8'd12, 0, 0, 0, 0, 0, 0},
		'{8'd170, 8'd85, 0, 0, 0, 0, 0, 0},
		'{8'd85, 8'd170, 0, 0, 0, 0, 0, 0},
		'{8'd1, 8'd1, 0, 0, 0, 0, 0, 0},
		'{8'd7, 8'd13, 0, 0, 0, 0, 0, 0}
	};

	// ring, segment, radius per phase; zero and 255 counts exercise the clamps
	logic [15:0] phase_cfg[10][3] = '{
		'{16'd2, 16'd3, 16'd1}, '{16'd254, 16'd254, 16'd65535}, '{16'd0, 16'd0, 16'd0},
		'{16'hFF, 16'hFF, 16'd65535}, '{16'h0101, 16'hFE02, 16'd128},
		'{16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0}
	};

	initial begin
		row_t r;
		int span;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RING_COUNT;
		cfg_data <= '0;
		start <= 1'b0;
		ring_index <= '0;
		segment_index <= '0;
		no_gaps = 0;
		m_rings = RING_COUNT_RST;
		m_segs = SEGMENT_COUNT_RST;
		m_radius = SPHERE_RADIUS_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) send_vertex(directed[k]);

		for (int p = 0; p < 10; p++) begin
			drain();
			if (p >= 5) begin
				phase_cfg[p][0] = 16'((($urandom_range(0, 1) != 0) ? $urandom_range(0, 12)
					: $urandom_range(0, 65535)));
				phase_cfg[p][1] = 16'((($urandom_range(0, 1) != 0) ? $urandom_range(0, 12)
					: $urandom_range(0, 65535)));
				phase_cfg[p][2] = 16'($urandom_range(0, 65535));
			end
			no_gaps = p >= 8;
			write_reg(REG_RING_COUNT, phase_cfg[p][0]);
			write_reg(REG_SEGMENT_COUNT, phase_cfg[p][1]);
			write_reg(REG_SPHERE_RADIUS, phase_cfg[p][2]);
			write_reg(REG_UNUSED, 16'($urandom));
			for (int n = 0; n < 114; n++) begin
				span = $urandom_range(0, 4);
				r = '{default: 0};
				if (span == 0) begin
					r.ring = 8'($urandom_range(0, 255));
					r.seg = 8'($urandom_range(0, 255));
				end else begin
					r.ring = 8'($urandom_range(0, m_rings + 1));
					r.seg = 8'($urandom_range(0, m_segs + 1));
				end
				send_vertex(r);
			end
		end

		drain();
		if (errors == 0) begin
			$display("tb_uv_sphere_vertex_generator passed");
		end else begin
			$display("tb_uv_sphere_vertex_generator failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_front.sv
hw/rtl/uvs_queue.sv
hw/rtl/uvs_back.sv
hw/rtl/uv_sphere_vertex_generator.sv
sim/tb_uv_sphere_vertex_generator.sv
